// ===== design/lirs_pkg.sv =====
// ----------------------------------------------------------------------------
// lirs_pkg - linear interpolation resampler shared definitions
// Widths, register indexes, sequencer types and the control program ROM.
// ----------------------------------------------------------------------------
package lirs_pkg;

    // default parameter values
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int MAX_UPSAMPLE_DEF = 8;
    localparam int MAX_CLIP_DEF     = 65536;

    // fixed register widths
    localparam int RATE_W     = 18;
    localparam int CLIP_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 18'd48000;
    localparam logic [RATE_W-1:0] TARGET_RATE_RST = 18'd48000;
    localparam logic [CLIP_W-1:0] CLIP_LENGTH_RST = 17'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_RATE = 2'd0,
        REG_TARGET_RATE = 2'd1,
        REG_CLIP_LENGTH = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_INTERP,
        MODE_PASS,
        MODE_ERR
    } t_mode;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_RESTART,
        OP_LD_TOTAL,
        OP_DIV_STEP,
        OP_SAVE_TOTAL,
        OP_LD_STEP,
        OP_SAVE_STEP,
        OP_TAKE_IN,
        OP_EMIT_PASS,
        OP_FINISH,
        OP_CHECK,
        OP_LD_INTERP,
        OP_EMIT_INTERP
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOT_INTERP,
        C_INTERP,
        C_CNT_MORE,
        C_LOOP_DONE
    } t_cond;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;

    // program addresses
    localparam t_upc A_SETUP  = 4'd0;
    localparam t_upc A_LD_TOT = 4'd1;
    localparam t_upc A_DIV_T  = 4'd2;
    localparam t_upc A_SV_TOT = 4'd3;
    localparam t_upc A_LD_STP = 4'd4;
    localparam t_upc A_DIV_S  = 4'd5;
    localparam t_upc A_SV_STP = 4'd6;
    localparam t_upc A_IDLE   = 4'd7;
    localparam t_upc A_PASS   = 4'd8;
    localparam t_upc A_FINISH = 4'd9;
    localparam t_upc A_CHECK  = 4'd10;
    localparam t_upc A_LD_INT = 4'd11;
    localparam t_upc A_DIV_I  = 4'd12;
    localparam t_upc A_EMIT_I = 4'd13;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  wait_in;   // hold until an input item is accepted
        logic  wait_out;  // hold until the output register is free
        t_upc  target;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic restart;
        logic in_valid;
        logic out_free;
        logic interp;
        logic cnt_more;
        logic loop_done;
    } t_seq_stat;

    // sequencer commands to the datapath
    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_seq_ctrl;

    function automatic t_uword uw(input t_op op, input t_cond cond, input logic wi,
                                  input logic wo, input t_upc tgt);
        t_uword w;
        w.op       = op;
        w.cond     = cond;
        w.wait_in  = wi;
        w.wait_out = wo;
        w.target   = tgt;
        return w;
    endfunction

    // control program
    function automatic t_uword ucode(input t_upc addr);
        t_uword w;
        unique case (addr)
            // setup after reset or a register write
            A_SETUP:  w = uw(OP_RESTART,     C_NOT_INTERP, 1'b0, 1'b0, A_IDLE);
            A_LD_TOT: w = uw(OP_LD_TOTAL,    C_NEXT,       1'b0, 1'b0, A_SETUP);
            A_DIV_T:  w = uw(OP_DIV_STEP,    C_CNT_MORE,   1'b0, 1'b0, A_DIV_T);
            A_SV_TOT: w = uw(OP_SAVE_TOTAL,  C_NEXT,       1'b0, 1'b0, A_SETUP);
            A_LD_STP: w = uw(OP_LD_STEP,     C_NEXT,       1'b0, 1'b0, A_SETUP);
            A_DIV_S:  w = uw(OP_DIV_STEP,    C_CNT_MORE,   1'b0, 1'b0, A_DIV_S);
            A_SV_STP: w = uw(OP_SAVE_STEP,   C_NEXT,       1'b0, 1'b0, A_SETUP);
            // item intake and pass-through
            A_IDLE:   w = uw(OP_TAKE_IN,     C_INTERP,     1'b1, 1'b0, A_CHECK);
            A_PASS:   w = uw(OP_EMIT_PASS,   C_NEXT,       1'b0, 1'b1, A_SETUP);
            A_FINISH: w = uw(OP_FINISH,      C_ALWAYS,     1'b0, 1'b0, A_IDLE);
            // interpolation loop
            A_CHECK:  w = uw(OP_CHECK,       C_LOOP_DONE,  1'b0, 1'b0, A_FINISH);
            A_LD_INT: w = uw(OP_LD_INTERP,   C_NEXT,       1'b0, 1'b0, A_SETUP);
            A_DIV_I:  w = uw(OP_DIV_STEP,    C_CNT_MORE,   1'b0, 1'b0, A_DIV_I);
            A_EMIT_I: w = uw(OP_EMIT_INTERP, C_ALWAYS,     1'b0, 1'b1, A_CHECK);
            default:  w = uw(OP_NOP,         C_ALWAYS,     1'b0, 1'b0, A_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== design/lirs_useq.sv =====
// ----------------------------------------------------------------------------
// lirs_useq - control sequencer
// Step counter over the control ROM, with hold on handshakes and jumps.
// ----------------------------------------------------------------------------
module lirs_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lirs_pkg::t_seq_stat i_stat,
    output lirs_pkg::t_seq_ctrl o_ctrl
);

    lirs_pkg::t_upc   r_upc;
    lirs_pkg::t_upc   n_upc;
    lirs_pkg::t_uword w_word;
    logic             w_hold;
    logic             w_jump;

    assign w_word = lirs_pkg::ucode(r_upc);

    // stay on this word until the handshake it waits for goes through
    assign w_hold = (w_word.wait_in & ~i_stat.in_valid) |
                    (w_word.wait_out & ~i_stat.out_free);

    // jump condition
    always_comb begin
        unique case (w_word.cond)
            lirs_pkg::C_NEXT:       w_jump = 1'b0;
            lirs_pkg::C_ALWAYS:     w_jump = 1'b1;
            lirs_pkg::C_NOT_INTERP: w_jump = ~i_stat.interp;
            lirs_pkg::C_INTERP:     w_jump = i_stat.interp;
            lirs_pkg::C_CNT_MORE:   w_jump = i_stat.cnt_more;
            lirs_pkg::C_LOOP_DONE:  w_jump = i_stat.loop_done;
            default:                w_jump = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        priority if (i_stat.restart) begin
            n_upc = lirs_pkg::A_SETUP;
        end else if (w_hold) begin
            n_upc = r_upc;
        end else if (w_jump) begin
            n_upc = w_word.target;
        end else begin
            n_upc = r_upc + lirs_pkg::t_upc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= lirs_pkg::A_SETUP;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl.op       = w_hold ? lirs_pkg::OP_NOP : w_word.op;
    assign o_ctrl.in_ready = w_word.wait_in;

endmodule

// ===== design/linear_interp_resampler_core.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler_core - linear interpolation sample rate converter
// Resamples one clip of signed samples from source_rate to target_rate.
// ----------------------------------------------------------------------------
// A clip of clip_length samples is streamed in and round(clip_length *
// target_rate / source_rate) samples come out, each interpolated between the
// two source samples around its exact position. Equal or zero rates pass each
// sample through; upsampling beyond MAX_UPSAMPLE passes through with
// rate_error set. A small control program steps a shared restoring divider,
// one quotient bit per cycle. After reset or any register write the block
// runs a setup computing the output count and position step (a bare restart
// in pass-through), and takes no item meanwhile. Each item is taken, then
// emitted in pass-through, or when interpolating run through the divider and
// emitted once for every output it releases, and finished before the next
// item is taken; an emit waits while the output register is stalled.
// ----------------------------------------------------------------------------
module linear_interp_resampler_core #(
    parameter int SAMPLE_BITS  = lirs_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_UPSAMPLE = lirs_pkg::MAX_UPSAMPLE_DEF,
    parameter int MAX_CLIP     = lirs_pkg::MAX_CLIP_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // register writes
    input  logic                              i_cfg_we,
    input  logic [lirs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lirs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input samples
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample_in,
    // output samples
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]     o_sample_out,
    output logic                              o_clip_end,
    output logic                              o_rate_error
);

    localparam int SB       = SAMPLE_BITS;
    localparam int RATE_W   = lirs_pkg::RATE_W;
    localparam int CLIP_W   = lirs_pkg::CLIP_W;
    localparam int CLIP_CAP = (MAX_CLIP < 2**CLIP_W) ? MAX_CLIP : 2**CLIP_W - 1;
    localparam int TOT_W    = $clog2(MAX_UPSAMPLE * CLIP_CAP + 1);
    localparam int QW0      = (TOT_W > RATE_W) ? TOT_W : RATE_W;
    localparam int QW       = (QW0 > SB + 1) ? QW0 : SB + 1;
    localparam int DSR_W    = RATE_W + 1;
    localparam int ACC_A    = DSR_W + QW;
    localparam int ACC_B    = CLIP_W + RATE_W + 1;
    localparam int ACC_W    = (ACC_A > ACC_B) ? ACC_A : ACC_B;
    localparam int CNT_W    = $clog2(QW);
    localparam int IDX_W    = ((CLIP_W > RATE_W) ? CLIP_W : RATE_W) + 1;
    localparam int NUM_W    = SB + RATE_W + 2;
    localparam int PROD_W   = CLIP_W + RATE_W;
    localparam int MU_BITS  = $clog2(MAX_UPSAMPLE + 1);
    localparam int LIM_W    = RATE_W + MU_BITS;
    localparam int MCLIP_W  = $clog2(MAX_CLIP + 1);
    localparam int CCMP_W   = (MCLIP_W > CLIP_W) ? MCLIP_W : CLIP_W;

    // configuration registers
    logic [RATE_W-1:0] r_src;
    logic [RATE_W-1:0] r_to;
    logic [CLIP_W-1:0] r_len;

    // clip state
    logic [TOT_W-1:0]  r_total;
    logic [RATE_W-1:0] r_whole;
    logic [RATE_W-1:0] r_frac;
    logic [CLIP_W-1:0] r_in_pos;
    logic [TOT_W-1:0]  r_opos;
    logic [IDX_W-1:0]  r_index;
    logic [RATE_W-1:0] r_rem;
    logic signed [SB-1:0] r_prev;

    // working registers
    logic [PROD_W-1:0]       r_prod;
    logic signed [SB-1:0]    r_cur;
    logic                    r_last;
    logic signed [SB-1:0]    r_s0;
    logic signed [NUM_W-1:0] r_num;
    logic [ACC_W-1:0]        r_acc;
    logic [ACC_W-1:0]        r_dsh;
    logic [QW-1:0]           r_quo;
    logic [CNT_W-1:0]        r_cnt;

    // output register
    logic                 r_out_valid;
    logic signed [SB-1:0] r_out_sample;
    logic                 r_out_end;
    logic                 r_out_err;

    lirs_pkg::t_seq_stat w_stat;
    lirs_pkg::t_seq_ctrl w_ctrl;

    lirs_pkg::t_mode      w_mode;
    logic [LIM_W-1:0]     w_src_lim;
    logic [CLIP_W-1:0]    w_clip_eff;
    logic                 w_last;
    logic                 w_more;
    logic [IDX_W-1:0]     w_k_ext;
    logic signed [SB-1:0] w_s0;
    logic signed [SB:0]   w_diff;
    logic [ACC_W-1:0]     w_dvd_interp;
    logic                 w_ge;
    logic [RATE_W:0]      w_rem_sum;
    logic                 w_wrap;
    logic [SB-1:0]        w_interp;
    logic                 w_cfg_hit;
    logic                 w_out_free;

    // operating mode from the rate registers
    assign w_src_lim = LIM_W'(r_src) * LIM_W'(MAX_UPSAMPLE);
    always_comb begin
        priority if (r_src == '0 || r_to == '0 || r_src == r_to) begin
            w_mode = lirs_pkg::MODE_PASS;
        end else if (LIM_W'(r_to) > w_src_lim) begin
            w_mode = lirs_pkg::MODE_ERR;
        end else begin
            w_mode = lirs_pkg::MODE_INTERP;
        end
    end

    // effective clip length: zero counts as one, long clips saturate
    always_comb begin
        priority if (r_len == '0) begin
            w_clip_eff = CLIP_W'(1);
        end else if (CCMP_W'(r_len) > CCMP_W'(MAX_CLIP)) begin
            w_clip_eff = CLIP_W'(MAX_CLIP);
        end else begin
            w_clip_eff = r_len;
        end
    end

    assign w_last = (CLIP_W + 1)'(r_in_pos) + (CLIP_W + 1)'(1) >= (CLIP_W + 1)'(w_clip_eff);

    // output loop: emit while the next position lies inside the samples seen
    assign w_k_ext = IDX_W'(r_in_pos);
    assign w_more  = (r_opos < r_total) &&
                     ((r_index < w_k_ext) || (r_last && (r_index <= w_k_ext)));

    assign w_s0   = (r_index < w_k_ext) ? r_prev : r_cur;
    assign w_diff = (SB + 1)'(r_cur) - (SB + 1)'(w_s0);

    // offset dividend so the floored quotient is never negative
    assign w_dvd_interp = (ACC_W'(r_num) << 1) + ACC_W'(r_to) + (ACC_W'(r_to) << (SB + 1));

    // divider compare
    assign w_ge = r_acc >= r_dsh;

    // position step
    assign w_rem_sum = (RATE_W + 1)'(r_rem) + (RATE_W + 1)'(r_frac);
    assign w_wrap    = w_rem_sum >= (RATE_W + 1)'(r_to);

    // quotient carries an offset of 2^SB, which drops out modulo 2^SB
    assign w_interp = r_s0 + r_quo[SB-1:0];

    assign w_cfg_hit  = i_cfg_we && (i_cfg_idx == lirs_pkg::REG_SOURCE_RATE ||
                                     i_cfg_idx == lirs_pkg::REG_TARGET_RATE ||
                                     i_cfg_idx == lirs_pkg::REG_CLIP_LENGTH);
    assign w_out_free = ~r_out_valid | ~i_out_stall;

    assign w_stat.restart   = w_cfg_hit;
    assign w_stat.in_valid  = i_in_valid;
    assign w_stat.out_free  = w_out_free;
    assign w_stat.interp    = (w_mode == lirs_pkg::MODE_INTERP);
    assign w_stat.cnt_more  = (r_cnt != '0);
    assign w_stat.loop_done = ~w_more;

    lirs_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= lirs_pkg::SOURCE_RATE_RST;
            r_to  <= lirs_pkg::TARGET_RATE_RST;
            r_len <= lirs_pkg::CLIP_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lirs_pkg::REG_SOURCE_RATE: r_src <= i_cfg_data;
                lirs_pkg::REG_TARGET_RATE: r_to  <= i_cfg_data;
                lirs_pkg::REG_CLIP_LENGTH: r_len <= i_cfg_data[CLIP_W-1:0];
                default: ;
            endcase
        end
    end

    // clip state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_whole     <= '0;
            r_frac      <= '0;
            r_in_pos    <= '0;
            r_opos      <= '0;
            r_index     <= '0;
            r_rem       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (w_ctrl.op)
                lirs_pkg::OP_RESTART: begin
                    r_in_pos <= '0;
                    r_opos   <= '0;
                    r_index  <= '0;
                    r_rem    <= '0;
                    r_whole  <= '0;
                    r_frac   <= '0;
                    r_total  <= TOT_W'(w_clip_eff);
                end
                lirs_pkg::OP_SAVE_TOTAL: r_total <= r_quo[TOT_W-1:0];
                lirs_pkg::OP_SAVE_STEP: begin
                    r_whole <= r_quo[RATE_W-1:0];
                    r_frac  <= r_acc[RATE_W-1:0];
                end
                lirs_pkg::OP_EMIT_PASS: r_out_valid <= 1'b1;
                lirs_pkg::OP_EMIT_INTERP: begin
                    r_out_valid <= 1'b1;
                    r_opos      <= r_opos + TOT_W'(1);
                    r_rem       <= w_wrap ? RATE_W'(w_rem_sum - (RATE_W + 1)'(r_to))
                                          : RATE_W'(w_rem_sum);
                    r_index     <= r_index + IDX_W'(r_whole) + IDX_W'(w_wrap);
                end
                lirs_pkg::OP_FINISH: begin
                    r_prev <= r_cur;
                    if (r_last) begin
                        r_in_pos <= '0;
                        r_opos   <= '0;
                        r_index  <= '0;
                        r_rem    <= '0;
                    end else begin
                        r_in_pos <= r_in_pos + CLIP_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath working registers and output payload
    always_ff @(posedge i_clk) begin
        unique case (w_ctrl.op)
            lirs_pkg::OP_RESTART: r_prod <= PROD_W'(w_clip_eff) * PROD_W'(r_to);
            lirs_pkg::OP_LD_TOTAL: begin
                r_acc <= ACC_W'(r_prod) + ACC_W'(r_src >> 1);
                r_dsh <= ACC_W'(r_src) << (QW - 1);
                r_quo <= '0;
                r_cnt <= CNT_W'(QW - 1);
            end
            lirs_pkg::OP_LD_STEP: begin
                r_acc <= ACC_W'(r_src);
                r_dsh <= ACC_W'(r_to) << (QW - 1);
                r_quo <= '0;
                r_cnt <= CNT_W'(QW - 1);
            end
            lirs_pkg::OP_LD_INTERP: begin
                r_acc <= w_dvd_interp;
                r_dsh <= ACC_W'(r_to) << (SB + 1);
                r_quo <= '0;
                r_cnt <= CNT_W'(SB);
            end
            lirs_pkg::OP_DIV_STEP: begin
                if (w_ge) begin
                    r_acc <= r_acc - r_dsh;
                end
                r_quo <= {r_quo[QW-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            lirs_pkg::OP_TAKE_IN: begin
                r_cur  <= i_sample_in;
                r_last <= w_last;
            end
            lirs_pkg::OP_CHECK: begin
                r_s0  <= w_s0;
                r_num <= w_diff * $signed({1'b0, r_rem});
            end
            lirs_pkg::OP_EMIT_PASS: begin
                r_out_sample <= r_cur;
                r_out_end    <= r_last;
                r_out_err    <= (w_mode == lirs_pkg::MODE_ERR);
            end
            lirs_pkg::OP_EMIT_INTERP: begin
                r_out_sample <= w_interp;
                r_out_end    <= ((TOT_W + 1)'(r_opos) + (TOT_W + 1)'(1)) ==
                                (TOT_W + 1)'(r_total);
                r_out_err    <= 1'b0;
            end
            default: ;
        endcase
    end

    assign o_in_stall   = ~w_ctrl.in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_clip_end   = r_out_end;
    assign o_rate_error = r_out_err;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - linear_interp_resampler_core testbench
// Sends clips of Q1.15 samples through the resampler under many rate and
// length settings and compares each output item with a cycle-free predictor
// of the resampler. Both sides idle at random; the output side also holds off
// for a long stretch once so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lirs_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int MAX_BURST    = 17;        // most outputs one sample can release
    localparam int RANDOM_ITEMS = 200;
    localparam int SETTLE       = 100;       // cycles to let the block go quiet
    localparam int HOLD_OFF     = 300;       // long output hold-off, in cycles
    localparam int CYCLE_LIMIT  = 1_000_000;

    // config index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int COMMON_RATES [12] = '{8000, 11025, 16000, 22050, 24000, 32000,
                                         44100, 48000, 88200, 96000, 176400, 192000};

    typedef struct packed {
        logic signed [SB-1:0] sample;
        logic                 clip_end;
        logic                 rate_error;
    } t_out_sample;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic signed [SB-1:0]    sample;
        logic                    has_want;
        t_out_sample             want;
    } t_dir_row;

    localparam t_out_sample NO_WANT = '{16'sd0, 1'b0, 1'b0};

    // directed stimulus; typed results only where pass-through makes them obvious
    localparam int DIR_ROWS = 38;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // reset defaults: equal rates, one-sample clips
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh7FFF, 1'b1, '{16'sh7FFF, 1'b1, 1'b0}},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh8000, 1'b1, '{16'sh8000, 1'b1, 1'b0}},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh0000, 1'b1, '{16'sh0000, 1'b1, 1'b0}},
        '{ROW_CFG,    REG_CLIP_LENGTH, 18'd3, 16'sh0000, 1'b0, NO_WANT},
        '{ROW_CFG,    REG_SPARE,  18'h3FFFF, 16'sh0000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'shFFFF, 1'b1, '{16'shFFFF, 1'b0, 1'b0}},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh0001, 1'b1, '{16'sh0001, 1'b0, 1'b0}},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh5555, 1'b1, '{16'sh5555, 1'b1, 1'b0}},
        // excessive upsampling
        '{ROW_CFG,    REG_SOURCE_RATE, 18'd1, 16'sh0000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'shAAAA, 1'b1, '{16'shAAAA, 1'b0, 1'b1}},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh7FFF, 1'b1, '{16'sh7FFF, 1'b0, 1'b1}},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh8000, 1'b1, '{16'sh8000, 1'b1, 1'b1}},
        // zero rate, zero clip length
        '{ROW_CFG,    REG_SOURCE_RATE, 18'd0, 16'sh0000, 1'b0, NO_WANT},
        '{ROW_CFG,    REG_CLIP_LENGTH, 18'd0, 16'sh0000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh1234, 1'b1, '{16'sh1234, 1'b1, 1'b0}},
        // exactly 8x upsampling, full-scale step
        '{ROW_CFG,    REG_SOURCE_RATE, 18'd24000,  16'sh0000, 1'b0, NO_WANT},
        '{ROW_CFG,    REG_TARGET_RATE, 18'd192000, 16'sh0000, 1'b0, NO_WANT},
        '{ROW_CFG,    REG_CLIP_LENGTH, 18'd2,      16'sh0000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh8000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh7FFF, 1'b0, NO_WANT},
        // extreme downsampling: empty output
        '{ROW_CFG,    REG_SOURCE_RATE, 18'd192000, 16'sh0000, 1'b0, NO_WANT},
        '{ROW_CFG,    REG_TARGET_RATE, 18'd1,      16'sh0000, 1'b0, NO_WANT},
        '{ROW_CFG,    REG_CLIP_LENGTH, 18'd4,      16'sh0000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh7FFF, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh8000, 1'b0, NO_WANT},
        // full-width rates, nearly equal
        '{ROW_CFG,    REG_SOURCE_RATE, 18'h3FFFE, 16'sh0000, 1'b0, NO_WANT},
        '{ROW_CFG,    REG_TARGET_RATE, 18'h3FFFF, 16'sh0000, 1'b0, NO_WANT},
        '{ROW_CFG,    REG_CLIP_LENGTH, 18'd3,     16'sh0000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh7FFF, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh8000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh7FFF, 1'b0, NO_WANT},
        // oversized clip length saturates, clip left unfinished
        '{ROW_CFG,    REG_SOURCE_RATE, 18'd48000,  16'sh0000, 1'b0, NO_WANT},
        '{ROW_CFG,    REG_TARGET_RATE, 18'd44100,  16'sh0000, 1'b0, NO_WANT},
        '{ROW_CFG,    REG_CLIP_LENGTH, 18'h3FFFF,  16'sh0000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh0100, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'shFF00, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh4000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh0000, 1'b0, NO_WANT}
    };

    // DUT signals
    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    logic signed [SB-1:0]   i_sample_in = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic signed [SB-1:0]   o_sample_out;
    logic                   o_clip_end;
    logic                   o_rate_error;

    linear_interp_resampler_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_clip_end   (o_clip_end),
        .o_rate_error (o_rate_error)
    );

    // run bookkeeping
    t_out_sample due_samples [$];
    int          n_fail       = 0;
    int          n_in         = 0;
    int          n_out        = 0;
    int          n_writes     = 0;
    int          n_settings   = 0;
    int          n_interp_in  = 0;
    int          n_err_in     = 0;
    int          cycle_count  = 0;
    bit          idling_on    = 1'b1;
    int          hold_cycles  = 0;

    // predictor state
    logic [RATE_W-1:0]     src_rate;
    logic [RATE_W-1:0]     tgt_rate;
    logic [CLIP_W-1:0]     clip_len_reg;
    t_mode                 rs_mode;
    logic signed [SB-1:0]  prev_sample;
    longint                clip_eff;
    longint                out_total;
    longint                step_whole;
    longint                step_frac;
    longint                in_pos;
    longint                out_pos;
    longint                src_idx;
    longint                src_rem;

    // recompute clip geometry and position step from the registers
    function automatic void interp_restart();
        longint src;
        longint tgt;
        src        = src_rate;
        tgt        = tgt_rate;
        in_pos     = 0;
        out_pos    = 0;
        src_idx    = 0;
        src_rem    = 0;
        step_whole = 0;
        step_frac  = 0;
        clip_eff   = (clip_len_reg == 0) ? 1 : clip_len_reg;
        if (clip_eff > MAX_CLIP_DEF)
            clip_eff = MAX_CLIP_DEF;
        if (src == 0 || tgt == 0 || src == tgt) begin
            rs_mode   = MODE_PASS;
            out_total = clip_eff;
        end else if (tgt > MAX_UPSAMPLE_DEF * src) begin
            rs_mode   = MODE_ERR;
            out_total = clip_eff;
        end else begin
            rs_mode    = MODE_INTERP;
            out_total  = (clip_eff * tgt + src / 2) / src;
            step_whole = src / tgt;
            step_frac  = src % tgt;
        end
    endfunction

    function automatic void interp_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SOURCE_RATE: src_rate     = data[RATE_W-1:0];
            REG_TARGET_RATE: tgt_rate     = data[RATE_W-1:0];
            REG_CLIP_LENGTH: clip_len_reg = data[CLIP_W-1:0];
            default:         return;   // unused index: no effect at all
        endcase
        interp_restart();
    endfunction

    // queue the outputs that one accepted input sample releases
    function automatic void interp_predict(input logic signed [SB-1:0] cur);
        t_out_sample res;
        longint      s0;
        longint      tgt;
        longint      numer;
        longint      denom;
        longint      quot;
        longint      v;
        bit          last;
        int          n;
        tgt  = tgt_rate;
        last = (in_pos + 1 >= clip_eff);
        n    = 0;
        if (rs_mode != MODE_INTERP) begin
            res.sample     = cur;
            res.clip_end   = last;
            res.rate_error = (rs_mode == MODE_ERR);
            due_samples.push_back(res);
            out_pos++;
        end else begin
            while (n < MAX_BURST && out_pos < out_total &&
                   (src_idx < in_pos || (last && src_idx <= in_pos))) begin
                s0 = (src_idx < in_pos) ? longint'(prev_sample) : longint'(cur);
                // round to nearest, ties up: floor((2*d*rem + to) / (2*to))
                numer = 2 * (longint'(cur) - s0) * src_rem + tgt;
                denom = 2 * tgt;
                quot  = numer / denom;
                if ((numer % denom) != 0 && numer < 0)
                    quot = quot - 1;
                v = s0 + quot;
                res.sample     = v[SB-1:0];
                res.clip_end   = (out_pos + 1 == out_total);
                res.rate_error = 1'b0;
                due_samples.push_back(res);
                n++;
                out_pos++;
                src_idx += step_whole;
                src_rem += step_frac;
                if (src_rem >= tgt) begin
                    src_rem -= tgt;
                    src_idx++;
                end
            end
        end
        prev_sample = cur;
        if (last) begin
            in_pos  = 0;
            out_pos = 0;
            src_idx = 0;
            src_rem = 0;
        end else begin
            in_pos = in_pos + 1;
        end
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 192000);
        return COMMON_RATES[$urandom_range(0, 11)];
    endfunction

    function automatic logic signed [SB-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return prev_sample + $signed(16'($urandom_range(0, 64))) - 16'sd32;
            default: return $urandom;
        endcase
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stop with a failure if the run hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("linear_interp_resampler_core test failed");
        $finish;
    end

    // output side: random stall bursts plus the requested long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_out_stall <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // compare every accepted output item with the oldest expectation
    always @(posedge i_clk) begin : check_outputs
        t_out_sample want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_out++;
            if (due_samples.size() == 0) begin
                $error("unexpected output item: sample_out %0d", o_sample_out);
                n_fail++;
            end else begin
                want = due_samples.pop_front();
                if (o_sample_out !== want.sample) begin
                    $error("sample_out: expected %0d, got %0d", want.sample, o_sample_out);
                    n_fail++;
                end
                if (o_clip_end !== want.clip_end) begin
                    $error("clip_end: expected %0b, got %0b", want.clip_end, o_clip_end);
                    n_fail++;
                end
                if (o_rate_error !== want.rate_error) begin
                    $error("rate_error: expected %0b, got %0b", want.rate_error,
                           o_rate_error);
                    n_fail++;
                end
            end
        end
    end

    // stop offering, wait for every expected item, then let the block go quiet
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        while (due_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        drain_outputs();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        interp_reg_write(idx, data);
        n_writes++;
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [SB-1:0] smp, input bit has_want,
                               input t_out_sample want);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= smp;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (rs_mode == MODE_INTERP)
            n_interp_in++;
        if (rs_mode == MODE_ERR)
            n_err_in++;
        interp_predict(smp);
        // rows with a typed result replace the single predicted one
        if (has_want) begin
            void'(due_samples.pop_back());
            due_samples.push_back(want);
        end
        n_in++;
    endtask

    // one random register setting: mostly interpolation, plus every special mode
    task automatic configure_random();
        logic [RATE_W-1:0]     src;
        logic [RATE_W-1:0]     tgt;
        logic [CFG_DATA_W-1:0] clip;
        case ($urandom_range(0, 9))
            6: begin
                src = pick_rate();
                tgt = src;
            end
            7: begin
                src = ($urandom_range(0, 1) == 0) ? '0 : 18'($urandom_range(0, 18'h3FFFF));
                tgt = (src != 0) ? '0 : 18'($urandom_range(0, 18'h3FFFF));
            end
            8: begin
                src = $urandom_range(1, 23999);
                tgt = $urandom_range(8 * src + 1, 192000);
            end
            9: begin
                src = $urandom_range(0, 18'h3FFFF);
                tgt = $urandom_range(0, 18'h3FFFF);
            end
            default: begin
                do begin
                    src = pick_rate();
                    tgt = pick_rate();
                end while (src == tgt || 32'(tgt) > 8 * 32'(src));
            end
        endcase
        case ($urandom_range(0, 9))
            0:       clip = '0;
            1:       clip = $urandom_range(0, 18'h3FFFF);
            2:       clip = $urandom_range(13, 40);
            default: clip = $urandom_range(1, 12);
        endcase
        write_register(REG_SOURCE_RATE, CFG_DATA_W'(src));
        write_register(REG_TARGET_RATE, CFG_DATA_W'(tgt));
        write_register(REG_CLIP_LENGTH, clip);
    endtask

    // main sequence
    int n_random = 0;
    int phase    = 0;
    int n_plan   = 0;

    initial begin
        src_rate     = SOURCE_RATE_RST;
        tgt_rate     = TARGET_RATE_RST;
        clip_len_reg = CLIP_LENGTH_RST;
        prev_sample  = '0;
        interp_restart();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].kind == ROW_CFG)
                write_register(DIR_TABLE[r].idx, DIR_TABLE[r].data);
            else
                send_sample(DIR_TABLE[r].sample, DIR_TABLE[r].has_want, DIR_TABLE[r].want);
        end

        // random part, one register setting per phase
        while (n_random < RANDOM_ITEMS) begin
            if (n_random >= RANDOM_ITEMS * 4 / 5)
                idling_on = 1'b0;
            else
                idling_on = ($urandom_range(0, 3) != 0);
            if (phase == 0) begin
                // 8x upsampling so a long hold-off backs the block up
                write_register(REG_SOURCE_RATE, 18'd11025);
                write_register(REG_TARGET_RATE, 18'd88200);
                write_register(REG_CLIP_LENGTH, 18'd10);
                n_plan = 30;
            end else begin
                configure_random();
                if (clip_eff > 40)
                    n_plan = $urandom_range(1, 20);   // clip left unfinished
                else
                    n_plan = int'(clip_eff) * $urandom_range(1, 3);
                if (clip_eff > 1 && clip_eff <= 40 && $urandom_range(0, 4) == 0)
                    n_plan += $urandom_range(1, int'(clip_eff) - 1);
            end
            n_settings++;
            for (int k = 0; k < n_plan; k++) begin
                if (phase == 0 && k == 1)
                    hold_cycles = HOLD_OFF;
                if ((phase == 0 && k == n_plan / 2) || $urandom_range(0, 39) == 0)
                    drain_outputs();
                send_sample(random_sample(), 1'b0, NO_WANT);
                n_random++;
            end
            phase++;
        end

        idling_on = 1'b0;
        drain_outputs();

        $display("covered %0d samples in (%0d interpolated, %0d over the upsample limit)",
                 n_in, n_interp_in, n_err_in);
        $display("checked %0d samples out across %0d register writes, %0d random settings",
                 n_out, n_writes, n_settings);
        if (n_fail == 0)
            $display("linear_interp_resampler_core test passed");
        else
            $display("linear_interp_resampler_core test failed");
        $finish;
    end

endmodule
